### design/accumulator_alu_with_flag_defines.svh
// Assertion macros for the accumulator ALU.
`ifndef ACCUMULATOR_ALU_WITH_FLAG_DEFINES_SVH
`define ACCUMULATOR_ALU_WITH_FLAG_DEFINES_SVH

`ifndef SYNTHESIS
// Check outside reset.
`define AAF_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("accumulator_alu_with_flag: check failed");
// Check on every edge, reset included.
`define AAF_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("accumulator_alu_with_flag: check failed");
`else
`define AAF_ASSERT(label, prop)
`define AAF_ASSERT_ALWAYS(label, prop)
`endif

`endif

### design/acc_alu_pkg.sv
`timescale 1ns / 1ps
package acc_alu_pkg;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_MOD  = 3'd3;
  localparam logic [2:0] OP_SHF  = 3'd4;
  localparam logic [2:0] OP_AND  = 3'd5;
  localparam logic [2:0] OP_TEST = 3'd6;
  localparam logic [2:0] OP_PASS = 3'd7;

  localparam logic [1:0] EXT_BASE = 2'd0;
  localparam logic [1:0] EXT_DIV  = 2'd1;

  localparam logic [7:0] SHL_MAX  = 8'd7;
  localparam logic [7:0] SAR_MAX  = 8'd31;
  localparam logic [7:0] SEL_BYTE = 8'd128;
  localparam logic [31:0] NIB_MAX  = 32'h0000_000f;
  localparam logic [31:0] BYTE_MAX = 32'h0000_00ff;

  typedef struct packed {
    logic signed [31:0] accumulator;
    logic [7:0]         operand;
    logic [4:0]         mode;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic [7:0]         flag;
    logic               flag_valid;
    logic               error;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  rem;
    logic [31:0] quo;
    logic [7:0]  dvs;
  } div_t;

  typedef struct packed {
    logic [31:0] result;
    logic        sel_div;
    logic        sel_mod;
    logic        neg;
    logic [7:0]  flag;
    logic        flag_valid;
    logic        error;
  } side_t;

endpackage

### design/acc_alu_div_stage.sv
`timescale 1ns / 1ps
module acc_alu_div_stage import acc_alu_pkg::*; (
  input  logic clk,
  input  div_t d_in,
  output div_t d_out
);

  div_t nxt;

  // Eight restoring steps, one quotient bit each.
  always_comb begin
    logic [8:0] t;
    nxt = d_in;
    for (int i = 0; i < 8; i++) begin
      t = {nxt.rem, nxt.quo[31]};
      nxt.quo = {nxt.quo[30:0], 1'b0};
      if (t >= {1'b0, nxt.dvs}) begin
        nxt.rem = 8'(t - {1'b0, nxt.dvs});
        nxt.quo[0] = 1'b1;
      end else begin
        nxt.rem = t[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    d_out <= nxt;
  end

endmodule

### design/accumulator_alu_with_flag.sv
`timescale 1ns / 1ps
// Accumulator ALU with flag: one word is taken per clock while start is high
// and busy is low (busy is high only in reset). Every word returns exactly one
// result, shown for one cycle with done high; the receiver cannot stall, so
// results must be taken as they appear. The pipeline depth is set by the signed
// divide and modulo path: a 32-bit magnitude divided by the 8-bit operand in
// four pipelined stages of eight restoring steps each, between a registered
// operand stage (which also holds the multiplier) and a sign-fix output stage.
// Results are wrapped to DATA_WIDTH bits and sign-extended to 32.
`include "accumulator_alu_with_flag_defines.svh"
module accumulator_alu_with_flag import acc_alu_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

  localparam int WW = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;

  logic  take;
  logic  v [1:5];
  side_t side [1:5];
  div_t  dv [1:5];
  side_t side_next;
  div_t  dv_next;
  rsp_t  rsp_next;

  assign busy = rst;
  assign take = start && !busy;

  // Operand stage: decode, fast ops, multiply, divider setup.
  always_comb begin
    logic [1:0]  extra;
    logic [2:0]  op;
    logic [7:0]  amt;
    logic [31:0] acc;
    extra = req.mode[4:3];
    op = req.mode[2:0];
    acc = req.accumulator;
    amt = 8'(9'd256 - {1'b0, req.operand});
    if (amt > SAR_MAX) amt = SAR_MAX;
    side_next = '0;
    side_next.neg = acc[31];
    dv_next.rem = '0;
    dv_next.quo = acc[31] ? 32'(-acc) : acc;
    dv_next.dvs = req.operand;
    if (extra == EXT_BASE) begin
      case (op)
        OP_ADD: side_next.result = acc + {24'd0, req.operand};
        OP_SUB: side_next.result = acc - {24'd0, req.operand};
        OP_MUL: side_next.result = 32'(acc * {24'd0, req.operand});
        OP_MOD: begin
          if (req.operand == '0) side_next.error = 1'b1;
          else side_next.sel_mod = 1'b1;
        end
        OP_SHF: begin
          if (req.operand > SHL_MAX) side_next.result = $signed(acc) >>> amt[4:0];
          else side_next.result = acc << req.operand[2:0];
        end
        OP_AND: side_next.result = acc & {24'd0, req.operand};
        default: side_next.result = acc;
      endcase
      if (op == OP_TEST) begin
        side_next.flag_valid = 1'b1;
        if (req.operand == '0)
          side_next.flag = {7'd0, acc == '0};
        else if (req.operand < SEL_BYTE)
          side_next.flag = {7'd0, !acc[31] && acc != '0 && acc <= NIB_MAX};
        else
          side_next.flag = {7'd0, !acc[31] && acc != '0 && acc <= BYTE_MAX};
      end else if (op == OP_PASS) begin
        side_next.flag_valid = 1'b1;
        side_next.flag = req.operand;
      end
    end else begin
      side_next.flag_valid = 1'b1;
      if (extra == EXT_DIV && req.operand != '0) side_next.sel_div = 1'b1;
      else side_next.error = 1'b1;
    end
    if (side_next.error) side_next.result = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= 5; i++) v[i] <= 1'b0;
      done <= 1'b0;
    end else begin
      v[1] <= take;
      for (int i = 2; i <= 5; i++) v[i] <= v[i-1];
      done <= v[5];
    end
    side[1] <= side_next;
    dv[1] <= dv_next;
    for (int i = 2; i <= 5; i++) side[i] <= side[i-1];
    rsp <= rsp_next;
  end

  for (genvar k = 1; k <= 4; k++) begin : g_div
    acc_alu_div_stage u_stage (
      .clk   (clk),
      .d_in  (dv[k]),
      .d_out (dv[k+1])
    );
  end

  // Output stage: sign fix, select, wrap to the configured width.
  always_comb begin
    logic [31:0] val;
    logic [31:0] rem32;
    rem32 = {24'd0, dv[5].rem};
    val = side[5].result;
    if (side[5].sel_div) val = side[5].neg ? 32'(-dv[5].quo) : dv[5].quo;
    else if (side[5].sel_mod) val = side[5].neg ? 32'(-rem32) : rem32;
    for (int i = 0; i < 32; i++) begin
      rsp_next.result[i] = (i < WW) ? val[i] : val[WW-1];
    end
    rsp_next.flag = side[5].flag;
    rsp_next.flag_valid = side[5].flag_valid;
    rsp_next.error = side[5].error;
  end

  `AAF_ASSERT(a_enter, v[1] == $past(take))
  `AAF_ASSERT(a_err_zero, (done && rsp.error) |-> (rsp.result == '0))
  `AAF_ASSERT(a_flag_idle, (done && !rsp.flag_valid) |-> (rsp.flag == '0))
  `AAF_ASSERT_ALWAYS(a_busy_rst, busy == rst)

endmodule

### test/tb.sv
`timescale 1ns / 1ps
module tb;
  import acc_alu_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t req = '0;
  logic done;
  rsp_t rsp;

  accumulator_alu_with_flag u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req(req), .done(done), .rsp(rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  req_t pending_words[$];
  rsp_t expected_rsp[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit stim_done = 1'b0;
  int gap_left = 0;

  localparam int unsigned CYCLE_LIMIT = 200000;

  // Compute the ALU answer for one word, 32-bit datapath.
  function automatic rsp_t alu_answer(req_t w);
    rsp_t r;
    logic signed [31:0] acc;
    logic [31:0] d32;
    logic [2:0] opc;
    logic [1:0] ext;
    int unsigned amt;
    acc = w.accumulator;
    d32 = {24'd0, w.operand};
    opc = w.mode[2:0];
    ext = w.mode[4:3];
    r = '0;
    if (ext == EXT_BASE) begin
      case (opc)
        OP_ADD: r.result = acc + d32;
        OP_SUB: r.result = acc - d32;
        OP_MUL: r.result = acc * d32;
        OP_MOD: begin
          if (w.operand == 8'd0) r.error = 1'b1;
          else r.result = acc % $signed(d32);
        end
        OP_SHF: begin
          if (w.operand > SHL_MAX) begin
            amt = 256 - w.operand;
            if (amt > 31) amt = 31;
            r.result = acc >>> amt;
          end else begin
            r.result = acc << w.operand;
          end
        end
        OP_AND: r.result = acc & d32;
        default: r.result = acc;
      endcase
      if (opc == OP_TEST) begin
        r.flag_valid = 1'b1;
        if (w.operand == 8'd0) r.flag = {7'd0, acc == 0};
        else if (w.operand < SEL_BYTE) r.flag = {7'd0, acc > 0 && acc <= $signed(NIB_MAX)};
        else r.flag = {7'd0, acc > 0 && acc <= $signed(BYTE_MAX)};
      end else if (opc == OP_PASS) begin
        r.flag_valid = 1'b1;
        r.flag = w.operand;
      end
    end else begin
      r.flag_valid = 1'b1;
      if (ext == EXT_DIV && w.operand != 8'd0) r.result = acc / $signed(d32);
      else r.error = 1'b1;
    end
    if (r.error) r.result = '0;
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
  endtask

  function automatic logic signed [31:0] pick_acc();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $signed(32'($urandom_range(0, 300)));
      3: return -$signed(32'($urandom_range(0, 300)));
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic logic [7:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'($urandom_range(0, 8));
      2: return 8'($urandom_range(224, 255));
      default: return 8'($urandom());
    endcase
  endfunction

  // Driver: change inputs on the falling edge.
  always @(negedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        void'(pending_words.pop_front());
        if ($urandom_range(0, 3) == 0) begin
          gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_words.size() > 0) begin
        start <= 1'b1;
        req <= pending_words[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: sample on the rising edge.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && start && !busy) expected_rsp.push_back(alu_answer(req));
    if (!rst && done) begin
      if (expected_rsp.size() == 0) begin
        report("unexpected word", rsp.result, '0);
      end else begin
        rsp_t w;
        w = expected_rsp.pop_front();
        if (rsp.result !== w.result) report("result", rsp.result, w.result);
        if (rsp.flag !== w.flag) report("flag", rsp.flag, w.flag);
        if (rsp.flag_valid !== w.flag_valid) report("flag_valid", rsp.flag_valid, w.flag_valid);
        if (rsp.error !== w.error) report("error", rsp.error, w.error);
      end
    end
  end

  initial begin
    req_t w;
    logic signed [31:0] accs[5];
    logic [7:0] ops[5];
    accs = '{32'sh8000_0000, 32'sh7fff_ffff, 0, -1, 32'sd15};
    ops = '{8'd0, 8'd255, 8'd7, 8'd8, 8'd128};
    for (int i = 0; i < 5; i++) begin
      for (int m = 0; m < 5; m++) begin
        w.accumulator = accs[i];
        w.operand = ops[(i + m) % 5];
        w.mode = (m == 4) ? 5'($urandom_range(8, 31)) : 5'((i * 5 + m) % 8);
        pending_words.push_back(w);
      end
    end
    // Boundaries of the range tests, then signed modulo and divide of a negative value.
    w = '{accumulator: 32'sd16, operand: 8'd1, mode: {EXT_BASE, OP_TEST}};
    pending_words.push_back(w);
    w = '{accumulator: 32'sd255, operand: 8'd200, mode: {EXT_BASE, OP_TEST}};
    pending_words.push_back(w);
    w = '{accumulator: 32'sd256, operand: 8'd200, mode: {EXT_BASE, OP_TEST}};
    pending_words.push_back(w);
    w = '{accumulator: -32'sd7, operand: 8'd3, mode: {EXT_BASE, OP_MOD}};
    pending_words.push_back(w);
    w = '{accumulator: -32'sd7, operand: 8'd2, mode: {EXT_DIV, OP_ADD}};
    pending_words.push_back(w);
    for (int i = 0; i < 950; i++) begin
      w.accumulator = pick_acc();
      w.operand = pick_operand();
      w.mode = ($urandom_range(0, 3) == 0) ? 5'($urandom()) : {2'($urandom_range(0, 1)),
                                                               3'($urandom())};
      pending_words.push_back(w);
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    wait (pending_words.size() == 0 && !start && expected_rsp.size() == 0);
    repeat (20) @(posedge clk);
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done || cycle_count >= CYCLE_LIMIT);
    if (stim_done && mismatches == 0 && expected_rsp.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
